// File: rtl/core/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg: shared definitions for the tiled pixel address pattern block
// Field widths, register indexes, layout codes, reset values, the
// configuration structure and the 16x16 subtile order table.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int TPA_COORD_BITS    = 13;
    localparam int TPA_STRIPE_PIXELS = 37;

    localparam int TPA_SIZE_W     = 14;
    localparam int TPA_COLOR_W    = 32;
    localparam int TPA_OFFSET_W   = 27;
    localparam int TPA_CFG_IDX_W  = 3;
    localparam int TPA_CFG_DATA_W = 32;

    localparam logic [TPA_OFFSET_W-1:0] TPA_OFFSET_MAX = '1;

    typedef enum logic [1:0] {
        LAYOUT_LINEAR = 2'd0,
        LAYOUT_YTILED = 2'd1,
        LAYOUT_AFBC   = 2'd2
    } tpa_layout_t;

    typedef enum logic {
        PATTERN_STRIPES = 1'b0,
        PATTERN_BORDER  = 1'b1
    } tpa_pattern_t;

    typedef enum logic [TPA_CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_ROW_STRIDE    = 3'd2,
        CFG_LAYOUT_MODE   = 3'd3,
        CFG_PATTERN_KIND  = 3'd4,
        CFG_STRIPE_ENABLE = 3'd5,
        CFG_FORE_COLOR    = 3'd6,
        CFG_BACK_COLOR    = 3'd7
    } tpa_cfg_idx_t;

    typedef struct packed {
        logic [TPA_SIZE_W-1:0]  image_width;
        logic [TPA_SIZE_W-1:0]  image_height;
        logic [TPA_SIZE_W-1:0]  row_stride;
        logic [1:0]             layout_mode;
        logic                   pattern_kind;
        logic                   stripe_enable;
        logic [TPA_COLOR_W-1:0] fore_color;
        logic [TPA_COLOR_W-1:0] back_color;
    } tpa_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tpa_fifo_stat_t;

    localparam logic [TPA_SIZE_W-1:0]  TPA_RST_WIDTH   = 14'd640;
    localparam logic [TPA_SIZE_W-1:0]  TPA_RST_HEIGHT  = 14'd480;
    localparam logic [TPA_SIZE_W-1:0]  TPA_RST_STRIDE  = 14'd640;
    localparam logic [TPA_COLOR_W-1:0] TPA_RST_FORE    = 32'hFFFF_FFFF;
    localparam logic [TPA_COLOR_W-1:0] TPA_RST_BACK    = 32'h0000_0000;

    // Subtile order inside a 16x16 tile, row index is the subtile column.
    localparam logic [3:0] TPA_AFBC_ORDER [16] = '{
        4'd2, 4'd1, 4'd14, 4'd13,
        4'd3, 4'd0, 4'd15, 4'd12,
        4'd4, 4'd7, 4'd8,  4'd11,
        4'd5, 4'd6, 4'd9,  4'd10
    };

    function automatic logic [3:0] tpa_afbc_order(input logic [1:0] sx, input logic [1:0] sy);
        return TPA_AFBC_ORDER[{sx, sy}];
    endfunction

endpackage

// File: rtl/core/tpa_pixel_if.sv
// ----------------------------------------------------------------------------
// tpa_pixel_if: pixel coordinate channel
// Valid/ready channel carrying one pixel coordinate per word.
// ----------------------------------------------------------------------------
interface tpa_pixel_if
    import tpa_pkg::*;
#(
    parameter int COORD_BITS = TPA_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: rtl/core/tpa_result_if.sv
// ----------------------------------------------------------------------------
// tpa_result_if: pixel result channel
// Valid/ready channel carrying word offset, color and bounds flag per word.
// ----------------------------------------------------------------------------
interface tpa_result_if
    import tpa_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [TPA_OFFSET_W-1:0] word_offset;
    logic [TPA_COLOR_W-1:0]  pixel_color;
    logic                    out_of_bounds;

    modport source (output valid, output word_offset, output pixel_color,
                    output out_of_bounds, input ready);
    modport sink   (input valid, input word_offset, input pixel_color,
                    input out_of_bounds, output ready);
endinterface

// File: rtl/core/tpa_front.sv
// ----------------------------------------------------------------------------
// tpa_front: coordinate intake and classification
// Accepts coordinates, forms the row product for the selected layout, the
// row stripe parity, the border hit and the bounds flag.
// ----------------------------------------------------------------------------
module tpa_front
    import tpa_pkg::*;
#(
    parameter int COORD_BITS    = TPA_COORD_BITS,
    parameter int STRIPE_PIXELS = TPA_STRIPE_PIXELS
)
(
    tpa_pixel_if.sink                          pixel,
    input  tpa_cfg_t                           cfg,
    input  tpa_fifo_stat_t                     fifo_stat,
    output logic                               push,
    output logic [COORD_BITS+TPA_SIZE_W-1:0]   row_prod,
    output logic [COORD_BITS-1:0]              col,
    output logic [4:0]                         row_low,
    output logic                               stripe_py,
    output logic                               border,
    output logic                               oob
);

    localparam int PROD_W    = COORD_BITS + TPA_SIZE_W;
    localparam int CMP_W     = ((COORD_BITS > TPA_SIZE_W) ? COORD_BITS : TPA_SIZE_W) + 1;
    localparam int REC_SHIFT = COORD_BITS + 8;
    localparam int REC_W     = REC_SHIFT + 1;
    localparam longint unsigned REC_VAL =
        ((64'd1 << REC_SHIFT) + STRIPE_PIXELS - 1) / STRIPE_PIXELS;
    localparam logic [REC_W-1:0] REC_MUL = REC_VAL[REC_W-1:0];

    logic [TPA_SIZE_W:0]         stride_sum;
    logic [TPA_SIZE_W:0]         width_sum;
    logic [COORD_BITS-1:0]       mul_a;
    logic [TPA_SIZE_W-1:0]       mul_b;
    logic [COORD_BITS+REC_W-1:0] y_rec;
    logic [CMP_W-1:0]            x_ext;
    logic [CMP_W-1:0]            y_ext;
    logic [CMP_W-1:0]            w_ext;
    logic [CMP_W-1:0]            h_ext;

    assign pixel.ready = !fifo_stat.full;
    assign push        = pixel.valid && !fifo_stat.full;

    // Tiles per row, rounded up: 32 wide for Y-tiled, 16 wide for AFBC.
    assign stride_sum = {1'b0, cfg.row_stride} + (TPA_SIZE_W+1)'(31);
    assign width_sum  = {1'b0, cfg.image_width} + (TPA_SIZE_W+1)'(15);

    always_comb
    begin
        priority if (cfg.layout_mode == LAYOUT_YTILED)
        begin
            mul_a = pixel.pixel_y >> 5;
            mul_b = TPA_SIZE_W'(stride_sum[TPA_SIZE_W:5]);
        end
        else if (cfg.layout_mode == LAYOUT_AFBC)
        begin
            mul_a = pixel.pixel_y >> 4;
            mul_b = TPA_SIZE_W'(width_sum[TPA_SIZE_W:4]);
        end
        else
        begin
            mul_a = pixel.pixel_y;
            mul_b = cfg.row_stride;
        end
    end

    assign row_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign col      = pixel.pixel_x;
    assign row_low  = pixel.pixel_y[4:0];

    // Parity of y / STRIPE_PIXELS through an exact reciprocal product.
    assign y_rec     = (COORD_BITS+REC_W)'(pixel.pixel_y) * (COORD_BITS+REC_W)'(REC_MUL);
    assign stripe_py = y_rec[REC_SHIFT];

    assign x_ext = CMP_W'(pixel.pixel_x);
    assign y_ext = CMP_W'(pixel.pixel_y);
    assign w_ext = CMP_W'(cfg.image_width);
    assign h_ext = CMP_W'(cfg.image_height);

    // x + 1 == width can only match a nonzero width, so no separate zero test.
    assign border = (x_ext == '0) || (y_ext == '0)
                 || ((x_ext + CMP_W'(1)) == w_ext)
                 || ((y_ext + CMP_W'(1)) == h_ext);
    assign oob    = (x_ext >= w_ext) || (y_ext >= h_ext);

endmodule

// File: rtl/core/tpa_fifo.sv
// ----------------------------------------------------------------------------
// tpa_fifo: two-entry queue between front and back
// Holds classified words so intake and result delivery stall independently.
// ----------------------------------------------------------------------------
module tpa_fifo
    import tpa_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             pop,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata,
    output tpa_fifo_stat_t   stat
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// File: rtl/core/tpa_back.sv
// ----------------------------------------------------------------------------
// tpa_back: offset completion and color selection
// Finishes the word offset for the layout, saturates it, picks the color
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module tpa_back
    import tpa_pkg::*;
#(
    parameter int COORD_BITS    = TPA_COORD_BITS,
    parameter int STRIPE_PIXELS = TPA_STRIPE_PIXELS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tpa_cfg_t                          cfg,
    input  tpa_fifo_stat_t                    fifo_stat,
    output logic                              pop,
    input  logic [COORD_BITS+TPA_SIZE_W-1:0]  row_prod,
    input  logic [COORD_BITS-1:0]             col,
    input  logic [4:0]                        row_low,
    input  logic                              stripe_py,
    input  logic                              border,
    input  logic                              oob,
    tpa_result_if.source                      result
);

    localparam int SUM_W     = COORD_BITS + 17;
    localparam int REC_SHIFT = COORD_BITS + 8;
    localparam int REC_W     = REC_SHIFT + 1;
    localparam longint unsigned REC_VAL =
        ((64'd1 << REC_SHIFT) + STRIPE_PIXELS - 1) / STRIPE_PIXELS;
    localparam logic [REC_W-1:0] REC_MUL = REC_VAL[REC_W-1:0];
    localparam int HDR_W     = 22;

    logic [TPA_SIZE_W:0]         width_sum;
    logic [TPA_SIZE_W:0]         height_sum;
    logic [HDR_W-1:0]            hdr_reg;
    logic [HDR_W:0]              hdr_sum;
    logic [HDR_W+2:0]            body_words;
    logic [SUM_W-1:0]            lin_off;
    logic [SUM_W-1:0]            yt_tile;
    logic [SUM_W-1:0]            yt_off;
    logic [SUM_W-1:0]            af_tile;
    logic [SUM_W-1:0]            af_off;
    logic [SUM_W-1:0]            off_sel;
    logic [TPA_OFFSET_W-1:0]     off_sat;
    logic [COORD_BITS+REC_W-1:0] x_rec;
    logic                        fore;
    logic                        valid_reg;
    logic [TPA_OFFSET_W-1:0]     offset_reg;
    logic [TPA_COLOR_W-1:0]      color_reg;
    logic                        oob_reg;

    // AFBC header block count depends on configuration only.
    assign width_sum  = {1'b0, cfg.image_width} + (TPA_SIZE_W+1)'(15);
    assign height_sum = {1'b0, cfg.image_height} + (TPA_SIZE_W+1)'(15);

    always_ff @(posedge clk)
    begin
        hdr_reg <= HDR_W'(width_sum[TPA_SIZE_W:4]) * HDR_W'(height_sum[TPA_SIZE_W:4]);
    end

    // 16-byte headers rounded up to 1 KiB, expressed in words.
    assign hdr_sum    = {1'b0, hdr_reg} + (HDR_W+1)'(63);
    assign body_words = {hdr_sum[HDR_W:6], 8'd0};

    assign lin_off = SUM_W'(row_prod) + SUM_W'(col);

    assign yt_tile = SUM_W'(row_prod) + SUM_W'(col >> 5);
    assign yt_off  = (yt_tile << 10) | SUM_W'({col[4:2], row_low, col[1:0]});

    assign af_tile = SUM_W'(row_prod) + SUM_W'(col >> 4);
    assign af_off  = ((af_tile << 8)
                   | SUM_W'({tpa_afbc_order(col[3:2], row_low[3:2]), row_low[1:0], col[1:0]}))
                   + SUM_W'(body_words);

    always_comb
    begin
        priority if (cfg.layout_mode == LAYOUT_YTILED)
            off_sel = yt_off;
        else if (cfg.layout_mode == LAYOUT_AFBC)
            off_sel = af_off;
        else
            off_sel = lin_off;
    end

    assign off_sat = (off_sel > SUM_W'(TPA_OFFSET_MAX)) ? TPA_OFFSET_MAX
                                                        : off_sel[TPA_OFFSET_W-1:0];

    assign x_rec = (COORD_BITS+REC_W)'(col) * (COORD_BITS+REC_W)'(REC_MUL);
    assign fore  = (cfg.pattern_kind == PATTERN_BORDER) ? border
                 : (cfg.stripe_enable && (x_rec[REC_SHIFT] != stripe_py));

    assign pop = !fifo_stat.empty && (!valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || result.ready)
            valid_reg <= !fifo_stat.empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            offset_reg <= off_sat;
            color_reg  <= fore ? cfg.fore_color : cfg.back_color;
            oob_reg    <= oob;
        end
    end

    assign result.valid         = valid_reg;
    assign result.word_offset   = offset_reg;
    assign result.pixel_color   = color_reg;
    assign result.out_of_bounds = oob_reg;

endmodule

// File: rtl/core/tiled_pixel_address_pattern_top.sv
// ----------------------------------------------------------------------------
// tiled_pixel_address_pattern_top: pixel word offset and test-pattern color
// Holds the configuration registers and joins front, queue and back.
// ----------------------------------------------------------------------------
// Usage:
// Coordinates arrive as words on the pixel channel (valid/ready). Each word
// yields exactly one result word on the result channel: the 27-bit word
// offset of the pixel in the frame buffer for the configured layout, its
// test-pattern color and an out-of-bounds flag.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per write; the user must write only while no word is in flight, as the
// block itself does not enforce it. Each accepted coordinate is written
// into the queue; the back pops it and registers its result word.
// Throughput: one word per clock cycle while the receiver holds ready high.
// The front does the single row multiply in the accepting cycle, the back
// does the final adds and saturation when it pops the word from the queue.
// Reset: configuration registers return to defaults (640x480, linear layout,
// stripes on, white on black) and the queue and output register empty.
// Stall: while the receiver holds ready low the result word stays put;
// the two-entry queue keeps accepting until it fills, then pixel ready
// drops and nothing is lost.
// ----------------------------------------------------------------------------
module tiled_pixel_address_pattern_top
    import tpa_pkg::*;
#(
    parameter int COORD_BITS    = TPA_COORD_BITS,
    parameter int STRIPE_PIXELS = TPA_STRIPE_PIXELS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [TPA_CFG_IDX_W-1:0]  cfg_index,
    input  logic [TPA_CFG_DATA_W-1:0] cfg_data,
    tpa_pixel_if.sink                 pixel,
    tpa_result_if.source              result
);

    localparam int PROD_W  = COORD_BITS + TPA_SIZE_W;
    localparam int FIFO_W  = PROD_W + COORD_BITS + 5 + 3;

    tpa_cfg_t              cfg_reg;
    tpa_fifo_stat_t        fifo_stat;
    logic                  push;
    logic                  pop;
    logic [FIFO_W-1:0]     fifo_wdata;
    logic [FIFO_W-1:0]     fifo_rdata;

    // Classified word as it leaves the front.
    logic [PROD_W-1:0]     f_row_prod;
    logic [COORD_BITS-1:0] f_col;
    logic [4:0]            f_row_low;
    logic                  f_stripe_py;
    logic                  f_border;
    logic                  f_oob;

    // The same word as the back sees it at the head of the queue.
    logic [PROD_W-1:0]     b_row_prod;
    logic [COORD_BITS-1:0] b_col;
    logic [4:0]            b_row_low;
    logic                  b_stripe_py;
    logic                  b_border;
    logic                  b_oob;

    // Configuration registers. Every index of the port maps to a register,
    // and each takes the low bits of the write data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= TPA_RST_WIDTH;
            cfg_reg.image_height  <= TPA_RST_HEIGHT;
            cfg_reg.row_stride    <= TPA_RST_STRIDE;
            cfg_reg.layout_mode   <= LAYOUT_LINEAR;
            cfg_reg.pattern_kind  <= PATTERN_STRIPES;
            cfg_reg.stripe_enable <= 1'b1;
            cfg_reg.fore_color    <= TPA_RST_FORE;
            cfg_reg.back_color    <= TPA_RST_BACK;
        end
        else if (cfg_we)
        begin
            unique case (tpa_cfg_idx_t'(cfg_index))
                CFG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[TPA_SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[TPA_SIZE_W-1:0];
                CFG_ROW_STRIDE:    cfg_reg.row_stride    <= cfg_data[TPA_SIZE_W-1:0];
                CFG_LAYOUT_MODE:   cfg_reg.layout_mode   <= cfg_data[1:0];
                CFG_PATTERN_KIND:  cfg_reg.pattern_kind  <= cfg_data[0];
                CFG_STRIPE_ENABLE: cfg_reg.stripe_enable <= cfg_data[0];
                CFG_FORE_COLOR:    cfg_reg.fore_color    <= cfg_data[TPA_COLOR_W-1:0];
                CFG_BACK_COLOR:    cfg_reg.back_color    <= cfg_data[TPA_COLOR_W-1:0];
            endcase
        end
    end

    tpa_front #(
        .COORD_BITS    (COORD_BITS),
        .STRIPE_PIXELS (STRIPE_PIXELS)
    ) u_front (
        .pixel     (pixel),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .row_prod  (f_row_prod),
        .col       (f_col),
        .row_low   (f_row_low),
        .stripe_py (f_stripe_py),
        .border    (f_border),
        .oob       (f_oob)
    );

    assign fifo_wdata = {f_row_prod, f_col, f_row_low, f_stripe_py, f_border, f_oob};

    tpa_fifo #(
        .WIDTH (FIFO_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .wdata (fifo_wdata),
        .rdata (fifo_rdata),
        .stat  (fifo_stat)
    );

    assign {b_row_prod, b_col, b_row_low, b_stripe_py, b_border, b_oob} = fifo_rdata;

    tpa_back #(
        .COORD_BITS    (COORD_BITS),
        .STRIPE_PIXELS (STRIPE_PIXELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .row_prod  (b_row_prod),
        .col       (b_col),
        .row_low   (b_row_low),
        .stripe_py (b_stripe_py),
        .border    (b_border),
        .oob       (b_oob),
        .result    (result)
    );

`ifndef SYNTHESIS
    // The queue can only be full when a result word is waiting at the output.
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> result.valid)
        else $error("pixel ready low with no result word pending");

    // An accepted word is either queued or at the output right after the edge that accepts it.
    a_word_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> (!fifo_stat.empty || result.valid))
        else $error("accepted word vanished from the pipeline");
`endif

endmodule

// File: test/tiled_pixel_address_pattern_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_pixel_address_pattern_top_test: self-checking bench for the block
// Feeds pixel coordinates through the valid/ready pixel channel under a
// series of register setups (linear, Y-tiled, 16x16 tiled and the reserved
// layout code, both patterns, extreme and random sizes), predicts every
// result word in the bench and compares it field by field with the block.
// ----------------------------------------------------------------------------
module tiled_pixel_address_pattern_top_test;
    import tpa_pkg::*;

    // Run shape.
    localparam int unsigned RANDOM_SETUPS   = 14;
    localparam int unsigned WORDS_PER_SETUP = 132;
    localparam int unsigned HOLD_SETUP      = 3;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned MAX_GAP         = 4;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned REPORT_LIMIT    = 10;

    // Frame buffer geometry.
    localparam longint unsigned YT_EDGE     = 32;
    localparam longint unsigned YT_COLUMN   = 4;
    localparam longint unsigned AF_EDGE     = 16;
    localparam longint unsigned AF_SUB      = 4;
    localparam longint unsigned AF_HDR      = 16;
    localparam longint unsigned AF_ALIGN    = 1024;
    localparam longint unsigned STRIPE      = TPA_STRIPE_PIXELS;
    localparam longint unsigned OFFSET_TOP  = (64'd1 << TPA_OFFSET_W) - 1;
    localparam int unsigned     COORD_RANGE = 1 << TPA_COORD_BITS;

    // Rank of each 4x4 subtile inside a 16x16 tile, one nibble per subtile,
    // indexed by (column * 4 + row).
    localparam logic [63:0] SUBTILE_RANK = {
        4'd10, 4'd9,  4'd6, 4'd5,  4'd11, 4'd8,  4'd7,  4'd4,
        4'd12, 4'd15, 4'd0, 4'd3,  4'd13, 4'd14, 4'd1,  4'd2
    };

    typedef struct packed {
        logic [TPA_COORD_BITS-1:0] x;
        logic [TPA_COORD_BITS-1:0] y;
    } pixel_coord_t;

    typedef struct packed {
        logic [TPA_OFFSET_W-1:0] word_offset;
        logic [TPA_COLOR_W-1:0]  pixel_color;
        logic                    out_of_bounds;
    } pixel_result_t;

    logic clk;
    logic rst_n;

    logic                      cfg_we    = 1'b0;
    logic [TPA_CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TPA_CFG_DATA_W-1:0] cfg_data  = '0;

    tpa_pixel_if #(.COORD_BITS(TPA_COORD_BITS)) pixel_ch ();
    tpa_result_if                               result_ch ();

    // Register contents as the block should hold them right now. They only
    // change while the block is idle, so the value at acceptance is the one
    // the block uses for that word.
    tpa_cfg_t cfg_now;

    pixel_coord_t  pending_pixels[$];
    pixel_result_t expected_results[$];

    int unsigned words_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned error_count   = 0;
    int unsigned setup_count   = 0;
    int unsigned cycle_count   = 0;

    // When set, neither side draws idle cycles.
    logic steady_flow = 1'b0;

    int unsigned send_gap;
    int unsigned recv_wait;
    int unsigned recv_next;
    int unsigned hold_left;
    logic        hold_start = 1'b0;

    tiled_pixel_address_pattern_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch.sink),
        .result    (result_ch.source)
    );

    // ------------------------------------------------------------------------
    // Prediction: word offset for the current layout, pattern color and the
    // bounds flag of one pixel, all in 64-bit arithmetic before saturation.
    // ------------------------------------------------------------------------
    function automatic pixel_result_t predict_pixel(tpa_cfg_t c,
                                                    logic [TPA_COORD_BITS-1:0] px,
                                                    logic [TPA_COORD_BITS-1:0] py);
        longint unsigned x, y, w, h, s;
        longint unsigned off, across, down, hdr, body, tile;
        int unsigned     sx, sy;
        logic            fore;
        pixel_result_t   r;
        x = px;
        y = py;
        w = c.image_width;
        h = c.image_height;
        s = c.row_stride;
        case (c.layout_mode)
            LAYOUT_YTILED:
            begin
                across = (s + YT_EDGE - 1) / YT_EDGE;
                tile   = (y / YT_EDGE) * across + x / YT_EDGE;
                off    = tile * YT_EDGE * YT_EDGE
                       + (((x % YT_EDGE) / YT_COLUMN) * YT_EDGE + (y % YT_EDGE)) * YT_COLUMN
                       + (x % YT_COLUMN);
            end
            LAYOUT_AFBC:
            begin
                // The body starts after one header per tile, rounded up.
                across = (w + AF_EDGE - 1) / AF_EDGE;
                down   = (h + AF_EDGE - 1) / AF_EDGE;
                hdr    = across * down * AF_HDR;
                body   = ((hdr + AF_ALIGN - 1) / AF_ALIGN) * AF_ALIGN;
                tile   = (y / AF_EDGE) * across + x / AF_EDGE;
                sx     = (x % AF_EDGE) / AF_SUB;
                sy     = (y % AF_EDGE) / AF_SUB;
                off    = body / 4 + tile * AF_EDGE * AF_EDGE
                       + SUBTILE_RANK[(sx * 4 + sy) * 4 +: 4] * AF_SUB * AF_SUB
                       + (y % AF_SUB) * AF_SUB + (x % AF_SUB);
            end
            // The reserved code falls back to the linear layout.
            default: off = y * s + x;
        endcase
        if (off > OFFSET_TOP)
            off = OFFSET_TOP;

        if (c.pattern_kind == PATTERN_STRIPES)
            fore = c.stripe_enable && (((x / STRIPE) % 2) != ((y / STRIPE) % 2));
        else
            fore = (x == 0) || (y == 0) || (w != 0 && x == w - 1) || (h != 0 && y == h - 1);

        r.word_offset   = off[TPA_OFFSET_W-1:0];
        r.pixel_color   = fore ? c.fore_color : c.back_color;
        r.out_of_bounds = (x >= w) || (y >= h);
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    // ------------------------------------------------------------------------
    // Clock and cycle limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout: %0d words still pending, %0d results outstanding",
                     pending_pixels.size(), expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offers the pending coordinates one word at a time. A word that
    // is accepted gets its expected result queued right away; after each
    // word the sender may idle for a few cycles before offering the next.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ch.valid   <= 1'b0;
            pixel_ch.pixel_x <= '0;
            pixel_ch.pixel_y <= '0;
            send_gap         <= 0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                expected_results.push_back(predict_pixel(cfg_now, pixel_ch.pixel_x,
                                                         pixel_ch.pixel_y));
                words_sent <= words_sent + 1;
            end
            if (!pixel_ch.valid || pixel_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    pixel_ch.valid <= 1'b0;
                    send_gap       <= send_gap - 1;
                end
                else if (pending_pixels.size() != 0)
                begin
                    pixel_ch.valid   <= 1'b1;
                    pixel_ch.pixel_x <= pending_pixels[0].x;
                    pixel_ch.pixel_y <= pending_pixels[0].y;
                    void'(pending_pixels.pop_front());
                    send_gap         <= draw_gap();
                end
                else
                begin
                    pixel_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long hold-off of the receiver, counted here so that the sender keeps
    // offering words while the result side is blocked.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted result word is checked against the oldest
    // expectation. After each word the receiver may stall for a few cycles.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_wait       <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_error($sformatf("result word with nothing expected: offset %0d color %h oob %b",
                                           result_ch.word_offset, result_ch.pixel_color,
                                           result_ch.out_of_bounds));
                end
                else
                begin
                    if (result_ch.word_offset   !== expected_results[0].word_offset ||
                        result_ch.pixel_color   !== expected_results[0].pixel_color ||
                        result_ch.out_of_bounds !== expected_results[0].out_of_bounds)
                    begin
                        report_error($sformatf(
                            "word %0d: expected offset %0d color %h oob %b, got offset %0d color %h oob %b",
                            words_checked, expected_results[0].word_offset,
                            expected_results[0].pixel_color, expected_results[0].out_of_bounds,
                            result_ch.word_offset, result_ch.pixel_color,
                            result_ch.out_of_bounds));
                    end
                    void'(expected_results.pop_front());
                    words_checked <= words_checked + 1;
                end
                recv_next = draw_gap();
            end
            else
            begin
                recv_next = (recv_wait != 0) ? recv_wait - 1 : 0;
            end
            recv_wait       <= recv_next;
            result_ch.ready <= (hold_left == 0) && (recv_next == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Queue pushes and idle checks happen on the falling
    // edge so they never share a time step with the driver and monitor.
    // ------------------------------------------------------------------------
    task automatic queue_pixel(logic [TPA_COORD_BITS-1:0] x, logic [TPA_COORD_BITS-1:0] y);
        pixel_coord_t c;
        c.x = x;
        c.y = y;
        pending_pixels.push_back(c);
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || pixel_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(tpa_cfg_idx_t idx, logic [TPA_CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Writes every register once, only after the block has gone idle.
    task automatic setup(logic [TPA_SIZE_W-1:0] w, logic [TPA_SIZE_W-1:0] h,
                         logic [TPA_SIZE_W-1:0] s, logic [1:0] layout, logic kind,
                         logic stripes, logic [TPA_COLOR_W-1:0] fore,
                         logic [TPA_COLOR_W-1:0] back);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, TPA_CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, TPA_CFG_DATA_W'(h));
        write_reg(CFG_ROW_STRIDE, TPA_CFG_DATA_W'(s));
        write_reg(CFG_LAYOUT_MODE, TPA_CFG_DATA_W'(layout));
        write_reg(CFG_PATTERN_KIND, TPA_CFG_DATA_W'(kind));
        write_reg(CFG_STRIPE_ENABLE, TPA_CFG_DATA_W'(stripes));
        write_reg(CFG_FORE_COLOR, fore);
        write_reg(CFG_BACK_COLOR, back);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_now.image_width   = w;
        cfg_now.image_height  = h;
        cfg_now.row_stride    = s;
        cfg_now.layout_mode   = layout;
        cfg_now.pattern_kind  = kind;
        cfg_now.stripe_enable = stripes;
        cfg_now.fore_color    = fore;
        cfg_now.back_color    = back;
        setup_count++;
        @(negedge clk);
    endtask

    // Sizes lean small, with the range ends drawn now and then.
    function automatic logic [TPA_SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 1;
        else if (r == 1)
            return COORD_RANGE;
        else if (r == 2)
            return $urandom_range(1, 64);
        else if (r == 9)
            return $urandom_range(1, COORD_RANGE);
        else
            return $urandom_range(1, 2048);
    endfunction

    function automatic logic [1:0] pick_layout();
        int unsigned r;
        r = $urandom_range(0, 8);
        if (r == 8)
            return 2'd3;
        else
            return r % 3;
    endfunction

    // Mostly inside the image, some on its last line and just past it,
    // some on stripe boundaries and some across the whole coordinate range.
    function automatic logic [TPA_COORD_BITS-1:0] pick_coord(logic [TPA_SIZE_W-1:0] size);
        int unsigned span, r;
        span = (size == 0) ? 1 : ((size > COORD_RANGE) ? COORD_RANGE : size);
        r    = $urandom_range(0, 9);
        if (r <= 5)
            return $urandom_range(0, span - 1);
        else if (r == 6)
            return size - 1;
        else if (r == 7)
            return size;
        else if (r == 8)
            return STRIPE * $urandom_range(1, 221) - 1 + $urandom_range(0, 1);
        else
            return $urandom();
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed corners, random setups, drain, verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        pixel_ch.valid   = 1'b0;
        pixel_ch.pixel_x = '0;
        pixel_ch.pixel_y = '0;
        result_ch.ready  = 1'b0;
        rst_n            = 1'b0;

        cfg_now.image_width   = TPA_RST_WIDTH;
        cfg_now.image_height  = TPA_RST_HEIGHT;
        cfg_now.row_stride    = TPA_RST_STRIDE;
        cfg_now.layout_mode   = LAYOUT_LINEAR;
        cfg_now.pattern_kind  = PATTERN_STRIPES;
        cfg_now.stripe_enable = 1'b1;
        cfg_now.fore_color    = TPA_RST_FORE;
        cfg_now.back_color    = TPA_RST_BACK;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setup: image corners, just outside each edge, the far
        // corner of the coordinate range and the first stripe boundaries.
        queue_pixel(0, 0);
        queue_pixel(639, 479);
        queue_pixel(640, 479);
        queue_pixel(639, 480);
        queue_pixel(8191, 8191);
        queue_pixel(36, 36);
        queue_pixel(37, 0);
        queue_pixel(74, 37);

        // Y-tiled with the stripes switched off.
        setup(100, 70, 100, LAYOUT_YTILED, PATTERN_STRIPES, 1'b0, 32'hFFFF_FFFF, 32'h0);
        queue_pixel(0, 0);
        queue_pixel(99, 69);
        queue_pixel(8191, 8191);

        // 16x16 tiles; header area rounds up to a whole body block.
        setup(100, 70, 1, LAYOUT_AFBC, PATTERN_STRIPES, 1'b1, 32'h0, 32'hFFFF_FFFF);
        queue_pixel(0, 0);
        queue_pixel(99, 69);
        queue_pixel(8191, 4095);
        queue_pixel(5, 9);

        // One-pixel border: the edges, one pixel inside and one outside.
        setup(64, 48, 64, LAYOUT_LINEAR, PATTERN_BORDER, 1'b0, 32'hA5A5_5A5A, 32'h1234_5678);
        queue_pixel(0, 17);
        queue_pixel(63, 47);
        queue_pixel(62, 46);
        queue_pixel(64, 5);

        // The reserved layout code addresses like the linear one.
        setup(200, 100, 300, 2'd3, PATTERN_STRIPES, 1'b1, 32'hFFFF_FFFF, 32'h0);
        queue_pixel(123, 45);
        queue_pixel(8191, 8191);

        // Zero size: no last column or row, everything out of bounds.
        setup(0, 0, 8192, LAYOUT_LINEAR, PATTERN_BORDER, 1'b1, 32'hFFFF_FFFF, 32'h0);
        queue_pixel(0, 5);
        queue_pixel(5, 0);
        queue_pixel(8191, 8191);

        // Oversized image in 16x16 tiles: the far pixel saturates the offset.
        setup(16383, 16383, 16383, LAYOUT_AFBC, PATTERN_BORDER, 1'b0, 32'h0, 32'hFFFF_FFFF);
        queue_pixel(8191, 8191);
        queue_pixel(0, 0);

        // Random setups. Every fourth one, and the one with the long
        // receiver hold-off, runs without idle cycles so the block fills up.
        for (int unsigned phase = 0; phase < RANDOM_SETUPS; phase++)
        begin
            setup(pick_size(), pick_size(), pick_size(), pick_layout(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(), $urandom());
            steady_flow = (phase % 4 == 3) || (phase == HOLD_SETUP);
            for (int unsigned n = 0; n < WORDS_PER_SETUP; n++)
                queue_pixel(pick_coord(cfg_now.image_width), pick_coord(cfg_now.image_height));
            if (phase == HOLD_SETUP)
            begin
                hold_start = 1'b1;
                @(negedge clk);
                hold_start = 1'b0;
            end
        end

        // Drain, then give late or extra words a chance to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d result words for %0d pixel words over %0d register setups",
                 words_checked, words_sent, setup_count);
        $display("Layouts: linear, Y-tiled, 16x16 tiled, reserved; both patterns; %0d errors",
                 error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tpa_pkg.sv
rtl/core/tpa_pixel_if.sv
rtl/core/tpa_result_if.sv
rtl/core/tpa_front.sv
rtl/core/tpa_fifo.sv
rtl/core/tpa_back.sv
rtl/core/tiled_pixel_address_pattern_top.sv
test/tiled_pixel_address_pattern_top_test.sv
